// ----- design/jmc_pkg.sv -----
// shared types and constants of the joystick to mouse conditioner
package jmc_pkg;

  localparam int ADC_W       = 12;
  localparam int SENS_W      = 8;
  localparam int DZ_W        = 11;
  localparam int MOVE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = 16;
  localparam int CAL_SAMPLES = 10;

  localparam int HALF_SCALE     = ((2 ** ADC_W) - 1) / 2;
  localparam int DEFAULT_CENTRE = 2 ** (ADC_W - 1);
  localparam int MOVE_LIMIT     = 127;
  localparam int SAT_LIMIT      = (MOVE_LIMIT + 1) * HALF_SCALE;
  localparam int PROD_W         = ADC_W + SENS_W;
  localparam int REM_W          = $clog2(HALF_SCALE + 1);
  localparam int QUO_W          = MOVE_W - 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_CAL    = 3'd4;

  localparam logic MODE_RUN = 1'b0;
  localparam logic MODE_CAL = 1'b1;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_CAL  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ADC_W-1:0] x_sample;
    logic [ADC_W-1:0] y_sample;
    logic             sample_ok;
  } jmc_in_t;

  typedef struct packed {
    logic                     report_kind;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic                     cal_ok;
    logic [ADC_W-1:0]         centre_x_out;
    logic [ADC_W-1:0]         centre_y_out;
  } jmc_out_t;

endpackage

// ----- design/jmc_scale_lane.sv -----
// one axis: bit-serial multiply by sensitivity, saturate or bit-serial divide by half scale
module jmc_scale_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [jmc_pkg::ADC_W-1:0]  mag_i,
  input  logic [jmc_pkg::SENS_W-1:0] sens_i,
  output logic                       busy_o,
  output logic [jmc_pkg::QUO_W-1:0]  quo_o
);
  import jmc_pkg::*;

  localparam int STEP_W = $clog2(SENS_W);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MUL  = 4'b0010,
    PH_SAT  = 4'b0100,
    PH_DIV  = 4'b1000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [ADC_W-1:0]    mag_q, mag_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]    dig_q, dig_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [ADC_W:0]      psum;
  logic [REM_W:0]      trial;
  logic [REM_W:0]      trial_sub;
  logic                qbit;

  always_comb begin
    psum      = {1'b0, prod_q[PROD_W-1:SENS_W]} + (prod_q[0] ? {1'b0, mag_q} : '0);
    trial     = {rem_q, dig_q[QUO_W-1]};
    trial_sub = trial - (REM_W+1)'(HALF_SCALE);
    qbit      = (trial >= (REM_W+1)'(HALF_SCALE));
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    dig_d   = dig_q;
    quo_d   = quo_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          prod_d  = {{ADC_W{1'b0}}, sens_i};
          mag_d   = mag_i;
          cnt_d   = '0;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        // multiplier bits leave at the bottom as the partial product enters at the top
        prod_d = {psum, prod_q[SENS_W-1:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(SENS_W - 1)) begin
          phase_d = PH_SAT;
        end
      end
      PH_SAT: begin
        if (prod_q >= PROD_W'(SAT_LIMIT)) begin
          quo_d   = QUO_W'(MOVE_LIMIT);
          phase_d = PH_IDLE;
        end else begin
          // quotient fits in QUO_W bits, so the upper bits already form the first remainder
          rem_d   = prod_q[QUO_W +: REM_W];
          dig_d   = prod_q[QUO_W-1:0];
          quo_d   = '0;
          cnt_d   = '0;
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        rem_d = qbit ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], qbit};
        dig_d = {dig_q[QUO_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(QUO_W - 1)) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    dig_q  <= dig_d;
    quo_q  <= quo_d;
  end

  assign busy_o = (phase_q != PH_IDLE);
  assign quo_o  = quo_q;

endmodule

// ----- design/jmc_cal_div.sv -----
// restoring divider, one quotient bit per cycle, for the calibration average
module jmc_cal_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [jmc_pkg::SUM_W-1:0] dividend_i,
  input  logic [jmc_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [jmc_pkg::ADC_W-1:0] quo_o
);
  import jmc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              qbit;

  always_comb begin
    trial     = {rem_q, num_q[SUM_W-1]};
    trial_sub = trial - {1'b0, den_q};
    qbit      = (trial >= {1'b0, den_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (busy_q) begin
      // quotient bits shift in where dividend bits shift out
      num_d = {num_q[SUM_W-2:0], qbit};
      rem_d = qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end else if (start_i) begin
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q[ADC_W-1:0];

endmodule

// ----- design/joystick_to_mouse_conditioner.sv -----
// top level: joystick sample conditioning into mouse movement and calibration reports
//
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one X/Y sample pair per item,
// either a calibration sample or a run sample. Output channel (out_valid_o/out_ready_i,
// out_data_o) gives a movement report or a calibration-finished report.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i), written while
// the block is idle; registers are enable, deadzone, sensitivity, y flip and the
// calibration gate, in that index order.
// One item at a time: in_ready_o is high only while no item is in work.
// A run sample that yields a report raises out_valid_o after these steps: the offsets
// are prepared, the per-axis serial unit runs (8 multiply steps, one saturation check,
// 7 divide steps), the results are collected and the output register is loaded; when
// both axes saturate, the divide steps are skipped. The last calibration sample runs
// the 16-step serial divider before its report, or skips it when it had no valid read.
// Other samples free the input after preparation. After a reporting item the next one
// is accepted only once its report is loaded into the output register.
// Reset restores register defaults, centre 2048 on both axes, not calibrated.
// A stalled receiver keeps its report in the output register; the next input item is
// accepted meanwhile, and its own report waits until the register is taken.
module joystick_to_mouse_conditioner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  jmc_pkg::jmc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output jmc_pkg::jmc_out_t              out_data_o
);
  import jmc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_CDIV  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // configuration
  logic              enable_q;
  logic [DZ_W-1:0]   deadzone_q;
  logic [SENS_W-1:0] sens_q;
  logic              invert_q;
  logic              auto_q;

  // control and block state
  state_e           state_q, state_d;
  logic [ADC_W-1:0] centre_x_q, centre_x_d;
  logic [ADC_W-1:0] centre_y_q, centre_y_d;
  logic             is_cal_q, is_cal_d;
  logic [CNT_W-1:0] taken_q, taken_d;
  logic [CNT_W-1:0] cal_valid_q, cal_valid_d;
  logic [SUM_W-1:0] sum_x_q, sum_x_d;
  logic [SUM_W-1:0] sum_y_q, sum_y_d;
  logic             out_valid_q, out_valid_d;

  // payload
  jmc_in_t  item_q, item_d;
  jmc_out_t res_q, res_d;
  jmc_out_t out_q, out_d;
  logic     sign_x_q, sign_x_d;
  logic     sign_y_q, sign_y_d;

  // datapath
  logic [ADC_W:0]    off_x, off_y;
  logic [ADC_W:0]    neg_x, neg_y;
  logic [ADC_W-1:0]  mag_x, mag_y;
  logic              nz_x, nz_y;
  logic [ADC_W-1:0]  lane_mag_x, lane_mag_y;
  logic [CNT_W-1:0]  taken_inc, valid_inc;
  logic [SUM_W-1:0]  sum_x_inc, sum_y_inc;
  logic              run_go;
  logic              lane_start, div_start;
  logic              lane_x_busy, lane_y_busy;
  logic [QUO_W-1:0]  quo_x, quo_y;
  logic              div_x_busy, div_y_busy;
  logic [ADC_W-1:0]  avg_x, avg_y;
  logic [MOVE_W-1:0] qx_ext, qy_ext;
  logic              out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      deadzone_q <= DZ_W'(100);
      sens_q     <= SENS_W'(5);
      invert_q   <= 1'b0;
      auto_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:      enable_q   <= cfg_wdata_i[0];
        REG_DEADZONE:    deadzone_q <= cfg_wdata_i[DZ_W-1:0];
        REG_SENSITIVITY: sens_q     <= cfg_wdata_i[SENS_W-1:0];
        REG_FLIP_Y:      invert_q   <= cfg_wdata_i[0];
        REG_AUTO_CAL:    auto_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // offsets from the centre, the deadzone test and the calibration running sums
  always_comb begin
    off_x = {1'b0, item_q.x_sample} - {1'b0, centre_x_q};
    off_y = {1'b0, item_q.y_sample} - {1'b0, centre_y_q};
    neg_x = -off_x;
    neg_y = -off_y;
    mag_x = off_x[ADC_W] ? neg_x[ADC_W-1:0] : off_x[ADC_W-1:0];
    mag_y = off_y[ADC_W] ? neg_y[ADC_W-1:0] : off_y[ADC_W-1:0];
    nz_x  = (mag_x >= ADC_W'(deadzone_q)) && (mag_x != '0);
    nz_y  = (mag_y >= ADC_W'(deadzone_q)) && (mag_y != '0);
    lane_mag_x = nz_x ? mag_x : '0;
    lane_mag_y = nz_y ? mag_y : '0;
    run_go = enable_q && item_q.sample_ok && !(auto_q && !is_cal_q) && (nz_x || nz_y);

    taken_inc = taken_q + 1'b1;
    valid_inc = cal_valid_q + CNT_W'(item_q.sample_ok);
    sum_x_inc = sum_x_q + (item_q.sample_ok ? SUM_W'(item_q.x_sample) : '0);
    sum_y_inc = sum_y_q + (item_q.sample_ok ? SUM_W'(item_q.y_sample) : '0);

    qx_ext = {1'b0, quo_x};
    qy_ext = {1'b0, quo_y};
  end

  always_comb begin
    state_d     = state_q;
    centre_x_d  = centre_x_q;
    centre_y_d  = centre_y_q;
    is_cal_d    = is_cal_q;
    taken_d     = taken_q;
    cal_valid_d = cal_valid_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    item_d      = item_q;
    res_d       = res_q;
    sign_x_d    = sign_x_q;
    sign_y_d    = sign_y_q;
    lane_start  = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (item_q.mode == MODE_CAL) begin
          if (taken_inc < CNT_W'(CAL_SAMPLES)) begin
            taken_d     = taken_inc;
            cal_valid_d = valid_inc;
            sum_x_d     = sum_x_inc;
            sum_y_d     = sum_y_inc;
            state_d     = ST_IDLE;
          end else begin
            // dividers keep their own copies, so the gathering state clears now
            taken_d     = '0;
            cal_valid_d = '0;
            sum_x_d     = '0;
            sum_y_d     = '0;
            if (valid_inc != '0) begin
              div_start = 1'b1;
              state_d   = ST_CDIV;
            end else begin
              res_d.report_kind  = KIND_CAL;
              res_d.move_x       = '0;
              res_d.move_y       = '0;
              res_d.cal_ok       = 1'b0;
              res_d.centre_x_out = centre_x_q;
              res_d.centre_y_out = centre_y_q;
              state_d            = ST_DONE;
            end
          end
        end else if (run_go) begin
          sign_x_d   = off_x[ADC_W];
          sign_y_d   = off_y[ADC_W] ^ invert_q;
          lane_start = 1'b1;
          state_d    = ST_SCALE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCALE: begin
        if (!lane_x_busy && !lane_y_busy) begin
          res_d.report_kind  = KIND_MOVE;
          res_d.move_x       = sign_x_q ? -qx_ext : qx_ext;
          res_d.move_y       = sign_y_q ? -qy_ext : qy_ext;
          res_d.cal_ok       = 1'b0;
          res_d.centre_x_out = centre_x_q;
          res_d.centre_y_out = centre_y_q;
          state_d            = ST_DONE;
        end
      end
      ST_CDIV: begin
        if (!div_x_busy && !div_y_busy) begin
          centre_x_d         = avg_x;
          centre_y_d         = avg_y;
          is_cal_d           = 1'b1;
          res_d.report_kind  = KIND_CAL;
          res_d.move_x       = '0;
          res_d.move_y       = '0;
          res_d.cal_ok       = 1'b1;
          res_d.centre_x_out = avg_x;
          res_d.centre_y_out = avg_y;
          state_d            = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d       = out_load ? res_q : out_q;
    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      centre_x_q  <= ADC_W'(DEFAULT_CENTRE);
      centre_y_q  <= ADC_W'(DEFAULT_CENTRE);
      is_cal_q    <= 1'b0;
      taken_q     <= '0;
      cal_valid_q <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      centre_x_q  <= centre_x_d;
      centre_y_q  <= centre_y_d;
      is_cal_q    <= is_cal_d;
      taken_q     <= taken_d;
      cal_valid_q <= cal_valid_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    out_q    <= out_d;
    sign_x_q <= sign_x_d;
    sign_y_q <= sign_y_d;
  end

  jmc_scale_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .mag_i   (lane_mag_x),
    .sens_i  (sens_q),
    .busy_o  (lane_x_busy),
    .quo_o   (quo_x)
  );

  jmc_scale_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .mag_i   (lane_mag_y),
    .sens_i  (sens_q),
    .busy_o  (lane_y_busy),
    .quo_o   (quo_y)
  );

  jmc_cal_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_x_inc),
    .divisor_i  (valid_inc),
    .busy_o     (div_x_busy),
    .quo_o      (avg_x)
  );

  jmc_cal_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_y_inc),
    .divisor_i  (valid_inc),
    .busy_o     (div_y_busy),
    .quo_o      (avg_y)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/jmc_checker.sv -----
// port-level checks of the conditioner, bound to the top level
module jmc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input jmc_pkg::jmc_out_t              out_data_o
);
  import jmc_pkg::*;

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output item changed while stalled");

  // movement stays within the symmetric limit and is not flagged as calibration
  a_move_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.report_kind == KIND_MOVE |->
      out_data_o.move_x != -8'sd128 && out_data_o.move_y != -8'sd128 &&
      out_data_o.cal_ok == 1'b0)
    else $error("movement item out of range or flagged as calibration");

  a_cal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.report_kind == KIND_CAL |->
      out_data_o.move_x == '0 && out_data_o.move_y == '0)
    else $error("calibration item carries movement");

  // no second item enters back to back with an accepted one
  a_no_accept_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted back to back");

endmodule

bind joystick_to_mouse_conditioner jmc_checker u_jmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
